@@ design/jacm_pkg.sv @@
// Shared types and constants for the joystick axis command mapper.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jacm_pkg;

   // Field and datapath widths
   localparam int AXIS_W      = 15;
   localparam int CMD_W       = 16;
   localparam int BTN_W       = 12;
   localparam int HOLD_W      = 8;
   localparam int PROD_W      = 32;
   localparam int MAG_W       = 30;
   localparam int RECIP_W     = 32;
   localparam int WIDE_W      = MAG_W + RECIP_W;
   localparam int RECIP_SHIFT = 45;
   localparam int QUO_W       = WIDE_W - RECIP_SHIFT;
   localparam int NUM_CMD     = 6;
   localparam int AXIS_IDX_W  = 3;
   localparam int NUM_STAB    = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int GRIP_W      = 8;
   localparam int TILT_W      = 7;
   localparam int AUX_W       = 8;
   localparam int LAMP_W      = 8;

   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef logic signed [CMD_W-1:0]  cmd_type;
   typedef logic [BTN_W-1:0]         btn_type;
   typedef logic [HOLD_W-1:0]        hold_type;
   typedef logic [AXIS_IDX_W-1:0]    axis_idx_type;

   // Scaling constants
   localparam cmd_type FULL_SCALE = 16'sd32767;
   localparam cmd_type AXIS_SPAN  = 16'sd10000;
   // ceil(2^45 / 10000) and ceil(2^45 / 20000): exact quotients for |x| < 2^30
   localparam logic [RECIP_W-1:0] RECIP_SPAN = 32'd3518437209;
   localparam logic [RECIP_W-1:0] RECIP_SENS = 32'd1759218605;

   // Command slots, in output order
   localparam axis_idx_type AX_PITCH = 3'd0;
   localparam axis_idx_type AX_ROLL  = 3'd1;
   localparam axis_idx_type AX_YAW   = 3'd2;
   localparam axis_idx_type AX_SURGE = 3'd3;
   localparam axis_idx_type AX_SWAY  = 3'd4;
   localparam axis_idx_type AX_DEPTH = 3'd5;

   // Button bit positions
   localparam int BTN_DEPTH_FLIP     = 0;
   localparam int BTN_JAW_CLOSE      = 1;
   localparam int BTN_JAW_CLOSE_HARD = 2;
   localparam int BTN_JAW_OPEN       = 3;
   localparam int BTN_FWD            = 4;
   localparam int BTN_REV            = 5;
   localparam int BTN_LIGHT          = 6;
   localparam int BTN_CAM_RAISE      = 7;
   localparam int BTN_TILT_DN        = 8;
   localparam int BTN_STAB_DEPTH     = 9;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_DEPTH   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUTTON_HOLDOFF = 4'd1;
   localparam hold_type HOLDOFF_RESET = 8'd10;

   // Discrete actuator codes
   localparam logic signed [GRIP_W-1:0] GRIP_CLOSE = 8'sd127;
   localparam logic signed [GRIP_W-1:0] GRIP_OPEN  = -8'sd127;
   localparam logic signed [TILT_W-1:0] TILT_RAISE = 7'sd60;
   localparam logic signed [TILT_W-1:0] TILT_LOWER = -7'sd60;
   localparam logic signed [AUX_W-1:0]  AUX_FWD    = 8'sd127;
   localparam logic signed [AUX_W-1:0]  AUX_REV    = -8'sd127;
   localparam logic signed [LAMP_W-1:0] LAMP_ON    = -8'sd126;

   // Controller to datapath commands
   typedef struct packed {
      logic         load;
      logic         mul;
      logic         div;
      logic         sat;
      logic         pass2;
      axis_idx_type axis;
      logic         publish;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

@@ design/jacm_if.sv @@
// Channel interfaces: poll input, command packet output and register write port.
// Depends on jacm_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface jacm_req_if;
   logic              valid;
   logic              ready;
   jacm_pkg::axis_type axis_pov_y;
   jacm_pkg::axis_type axis_pov_x;
   jacm_pkg::axis_type axis_r;
   jacm_pkg::axis_type axis_y;
   jacm_pkg::axis_type axis_x;
   jacm_pkg::axis_type axis_z;
   jacm_pkg::axis_type axis_u;
   jacm_pkg::axis_type axis_v;
   jacm_pkg::btn_type  buttons;

   modport source (output valid, axis_pov_y, axis_pov_x, axis_r, axis_y, axis_x,
                   axis_z, axis_u, axis_v, buttons, input ready);
   modport sink   (input valid, axis_pov_y, axis_pov_x, axis_r, axis_y, axis_x,
                   axis_z, axis_u, axis_v, buttons, output ready);
endinterface

interface jacm_rsp_if;
   logic                                     valid;
   logic                                     ready;
   jacm_pkg::cmd_type                        pitch_cmd;
   jacm_pkg::cmd_type                        roll_cmd;
   jacm_pkg::cmd_type                        yaw_cmd;
   jacm_pkg::cmd_type                        surge_cmd;
   jacm_pkg::cmd_type                        sway_cmd;
   jacm_pkg::cmd_type                        depth_cmd;
   logic signed [jacm_pkg::GRIP_W-1:0]       grip_cmd;
   logic signed [jacm_pkg::TILT_W-1:0]       tilt_cmd;
   logic signed [jacm_pkg::AUX_W-1:0]        aux_thruster_cmd;
   logic signed [jacm_pkg::LAMP_W-1:0]       lamp_cmd;
   jacm_pkg::axis_type                       grip_rotate;
   logic [jacm_pkg::NUM_STAB-1:0]            stabilize_flags;

   modport source (output valid, pitch_cmd, roll_cmd, yaw_cmd, surge_cmd, sway_cmd,
                   depth_cmd, grip_cmd, tilt_cmd, aux_thruster_cmd, lamp_cmd,
                   grip_rotate, stabilize_flags, input ready);
   modport sink   (input valid, pitch_cmd, roll_cmd, yaw_cmd, surge_cmd, sway_cmd,
                   depth_cmd, grip_cmd, tilt_cmd, aux_thruster_cmd, lamp_cmd,
                   grip_rotate, stabilize_flags, output ready);
endinterface

interface jacm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [jacm_pkg::CSR_IDX_W-1:0]      index;
   logic [jacm_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/jacm_dpath.sv @@
// Datapath: poll capture, shared multiply / reciprocal-divide / saturate unit,
// stabilize toggles, registers and the output packet register.
// Depends on jacm_pkg and jacm_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module jacm_dpath import jacm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output ctl_sts_type           sts,
   input  axis_type              in_pov_y,
   input  axis_type              in_pov_x,
   input  axis_type              in_r,
   input  axis_type              in_y,
   input  axis_type              in_x,
   input  axis_type              in_z,
   input  axis_type              in_u,
   input  axis_type              in_v,
   input  btn_type               in_buttons,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   jacm_rsp_if.source            rsp
);

   // Captured poll
   axis_type                 axis_ff [NUM_CMD];
   cmd_type                  sens_ff;
   axis_type                 rot_ff;
   btn_type                  btn_ff;

   // Arithmetic pipeline registers
   logic signed [PROD_W-1:0] prod_ff;
   logic [WIDE_W-1:0]        wide_ff;
   logic                     neg_ff;
   cmd_type                  stage1_ff;
   cmd_type                  res_ff [NUM_CMD];

   // Registers and toggle state
   logic                     invert_depth_ff;
   hold_type                 holdoff_ff;
   logic [NUM_STAB-1:0]      hold_ff;
   logic [NUM_STAB-1:0]      hold_in;
   hold_type                 wait_ff [NUM_STAB];
   hold_type                 wait_in [NUM_STAB];

   // Output packet register
   logic                     rsp_valid_ff;

   cmd_type                  op_a;
   cmd_type                  op_b;
   logic signed [PROD_W-1:0] op_a_ext;
   logic signed [PROD_W-1:0] op_b_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_abs;
   logic [MAG_W-1:0]         mag;
   logic [RECIP_W-1:0]       recip;
   logic [WIDE_W-1:0]        wide_in;
   logic [QUO_W-1:0]         quo;
   logic [CMD_W-1:0]         sat_mag;
   cmd_type                  s_pos;
   cmd_type                  s_val;
   logic                     flip;
   cmd_type                  sat_out;
   cmd_type                  z_ext;
   cmd_type                  u_ext;
   cmd_type                  sel_axis;

   assign sts.slot_free = !rsp_valid_ff || rsp.ready;

   // Multiply: axis (depth: span minus axis) by full scale, or command by sensitivity
   always_comb begin
      sel_axis = {axis_ff[cmd.axis][AXIS_W-1], axis_ff[cmd.axis]};
      if (cmd.pass2) begin
         op_a = stage1_ff;
         op_b = sens_ff;
      end else if (cmd.axis == AX_DEPTH) begin
         op_a = AXIS_SPAN - sel_axis;
         op_b = FULL_SCALE;
      end else begin
         op_a = sel_axis;
         op_b = FULL_SCALE;
      end
   end

   assign op_a_ext = op_a;
   assign op_b_ext = op_b;
   assign prod_in  = op_a_ext * op_b_ext;

   // Magnitude times reciprocal: divide by 10000 or 20000
   assign prod_abs = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign mag      = prod_abs[MAG_W-1:0];
   assign recip    = (cmd.pass2 || (cmd.axis == AX_DEPTH)) ? RECIP_SENS : RECIP_SPAN;
   assign wide_in  = {{(WIDE_W-MAG_W){1'b0}}, mag} * {{(WIDE_W-RECIP_W){1'b0}}, recip};

   // Quotient, restore sign, clamp to full scale, apply the per-slot negation
   always_comb begin
      quo     = wide_ff[WIDE_W-1:RECIP_SHIFT];
      sat_mag = (quo > QUO_W'(FULL_SCALE)) ? FULL_SCALE : quo[CMD_W-1:0];
      s_pos   = sat_mag;
      s_val   = neg_ff ? -s_pos : s_pos;
      if (cmd.pass2) begin
         flip = (cmd.axis == AX_DEPTH) && btn_ff[BTN_DEPTH_FLIP];
      end else begin
         flip = (cmd.axis == AX_SURGE) || ((cmd.axis == AX_DEPTH) && invert_depth_ff);
      end
      sat_out = flip ? -s_val : s_val;
   end

   // Stabilize toggles with holdoff
   always_comb begin
      for (int i = 0; i < NUM_STAB; i++) begin
         hold_in[i] = hold_ff[i];
         wait_in[i] = wait_ff[i];
         if (in_buttons[BTN_STAB_DEPTH + i] && (wait_ff[i] == '0)) begin
            hold_in[i] = !hold_ff[i];
            wait_in[i] = (holdoff_ff == '0) ? '0 : holdoff_ff - 1'b1;
         end else if (wait_ff[i] != '0) begin
            wait_in[i] = wait_ff[i] - 1'b1;
         end
      end
   end

   // Capture the poll and advance the toggle state
   assign z_ext = {in_z[AXIS_W-1], in_z};
   assign u_ext = {in_u[AXIS_W-1], in_u};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         axis_ff[AX_PITCH] <= in_pov_y;
         axis_ff[AX_ROLL]  <= in_pov_x;
         axis_ff[AX_YAW]   <= in_r;
         axis_ff[AX_SURGE] <= in_y;
         axis_ff[AX_SWAY]  <= in_x;
         axis_ff[AX_DEPTH] <= z_ext[AXIS_W-1:0];
         sens_ff           <= u_ext + AXIS_SPAN;
         rot_ff            <= in_v;
         btn_ff            <= in_buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
         for (int i = 0; i < NUM_STAB; i++) begin
            wait_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         hold_ff <= hold_in;
         for (int i = 0; i < NUM_STAB; i++) begin
            wait_ff[i] <= wait_in[i];
         end
      end
   end

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_depth_ff <= 1'b0;
         holdoff_ff      <= HOLDOFF_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_INVERT_DEPTH) begin
            invert_depth_ff <= csr_data[0];
         end else if (csr_index == REG_BUTTON_HOLDOFF) begin
            holdoff_ff <= csr_data[HOLD_W-1:0];
         end
      end
   end

   // Arithmetic unit stages
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.div) begin
         wide_ff <= wide_in;
         neg_ff  <= prod_ff[PROD_W-1];
      end
      if (cmd.sat) begin
         if (cmd.pass2) begin
            res_ff[cmd.axis] <= sat_out;
         end else begin
            stage1_ff <= sat_out;
         end
      end
   end

   // Output packet register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp.pitch_cmd       <= res_ff[AX_PITCH];
         rsp.roll_cmd        <= res_ff[AX_ROLL];
         rsp.yaw_cmd         <= res_ff[AX_YAW];
         rsp.surge_cmd       <= res_ff[AX_SURGE];
         rsp.sway_cmd        <= res_ff[AX_SWAY];
         rsp.depth_cmd       <= res_ff[AX_DEPTH];
         rsp.grip_rotate     <= rot_ff;
         rsp.stabilize_flags <= hold_ff;
         // Open wins over either close
         if (btn_ff[BTN_JAW_OPEN]) begin
            rsp.grip_cmd <= GRIP_OPEN;
         end else if (btn_ff[BTN_JAW_CLOSE] || btn_ff[BTN_JAW_CLOSE_HARD]) begin
            rsp.grip_cmd <= GRIP_CLOSE;
         end else begin
            rsp.grip_cmd <= '0;
         end
         // Tilt up wins over tilt down
         if (btn_ff[BTN_CAM_RAISE]) begin
            rsp.tilt_cmd <= TILT_RAISE;
         end else if (btn_ff[BTN_TILT_DN]) begin
            rsp.tilt_cmd <= TILT_LOWER;
         end else begin
            rsp.tilt_cmd <= '0;
         end
         // Forward wins over reverse
         if (btn_ff[BTN_FWD]) begin
            rsp.aux_thruster_cmd <= AUX_FWD;
         end else if (btn_ff[BTN_REV]) begin
            rsp.aux_thruster_cmd <= AUX_REV;
         end else begin
            rsp.aux_thruster_cmd <= '0;
         end
         rsp.lamp_cmd <= btn_ff[BTN_LIGHT] ? LAMP_ON : '0;
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/jacm_ctrl.sv @@
// Controller: sequences the shared arithmetic unit over the six motion commands
// and hands the finished packet to the output register. Depends on jacm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jacm_ctrl import jacm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam logic [2:0] PH_MUL1 = 3'd0;
   localparam logic [2:0] PH_DIV1 = 3'd1;
   localparam logic [2:0] PH_SAT1 = 3'd2;
   localparam logic [2:0] PH_MUL2 = 3'd3;
   localparam logic [2:0] PH_DIV2 = 3'd4;
   localparam logic [2:0] PH_SAT2 = 3'd5;

   logic [1:0]   state_ff, state_in;
   logic [2:0]   phase_ff, phase_in;
   axis_idx_type axis_ff, axis_in;
   logic         running;

   // Next state: a multiply, divide and clamp pass, run twice for each command
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               phase_in = PH_MUL1;
               axis_in  = AX_PITCH;
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_SAT2) begin
               phase_in = PH_MUL1;
               if (axis_ff == AX_DEPTH) begin
                  state_in = ST_PUSH;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_PUSH: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MUL1;
         axis_ff  <= AX_PITCH;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
      end
   end

   // Decode commands; hold off the input while in reset
   assign running     = (state_ff == ST_RUN);
   assign req_ready   = (state_ff == ST_IDLE) && !reset;
   assign cmd.load    = req_ready && req_valid;
   assign cmd.mul     = running && ((phase_ff == PH_MUL1) || (phase_ff == PH_MUL2));
   assign cmd.div     = running && ((phase_ff == PH_DIV1) || (phase_ff == PH_DIV2));
   assign cmd.sat     = running && ((phase_ff == PH_SAT1) || (phase_ff == PH_SAT2));
   assign cmd.pass2   = (phase_ff == PH_MUL2) || (phase_ff == PH_DIV2)
                        || (phase_ff == PH_SAT2);
   assign cmd.axis    = axis_ff;
   assign cmd.publish = (state_ff == ST_PUSH) && sts.slot_free;

endmodule

`default_nettype wire

@@ design/joystick_axis_command_mapper.sv @@
// Top level of the joystick axis command mapper: controller, datapath, channels.
// Depends on jacm_pkg, jacm_if, jacm_ctrl and jacm_dpath.
//
//   channel  direction  carries
//   req_if   in         one joystick poll: eight axes and the button vector
//   rsp_if   out        one command packet per poll
//   csr_if   in         register writes: invert_depth (0), button_holdoff (1)
//
// A transaction runs from an accept cycle, through a run in which one shared
// multiplier and one reciprocal divider run three steps twice for each of six
// motion commands, to a hand-off cycle. The packet turns valid and the input
// turns ready again at the same clock edge, once the hand-off is done.
// The output register holds a packet while rsp_if stalls; the hand-off cycle
// waits only if the previous packet is still not taken.
// Synchronous reset clears toggles, counters and invert_depth; holdoff resets to 10.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_command_mapper import jacm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   jacm_req_if.sink   req_if,
   jacm_rsp_if.source rsp_if,
   jacm_csr_if.sink   csr_if
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;
   logic        req_ready;

   // Register writes are taken whenever out of reset
   assign csr_if.ready = !reset;
   assign req_if.ready = req_ready;

   jacm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (ctl_sts),
      .cmd       (ctl_cmd)
   );

   jacm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctl_cmd),
      .sts        (ctl_sts),
      .in_pov_y   (req_if.axis_pov_y),
      .in_pov_x   (req_if.axis_pov_x),
      .in_r       (req_if.axis_r),
      .in_y       (req_if.axis_y),
      .in_x       (req_if.axis_x),
      .in_z       (req_if.axis_z),
      .in_u       (req_if.axis_u),
      .in_v       (req_if.axis_v),
      .in_buttons (req_if.buttons),
      .csr_we     (csr_if.valid),
      .csr_index  (csr_if.index),
      .csr_data   (csr_if.data),
      .rsp        (rsp_if)
   );

`ifndef SYNTH
   // Only one unit step or hand-off happens in a cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_cmd.load, ctl_cmd.mul, ctl_cmd.div, ctl_cmd.sat, ctl_cmd.publish}))
      else $error("more than one datapath command at once");

   // A packet is handed over only into a free output slot
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.publish |-> (!rsp_if.valid || rsp_if.ready))
      else $error("packet handed over onto an unread packet");

   // Work on a poll blocks the next poll
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("ready while a poll is in progress");
`endif

endmodule

`default_nettype wire

@@ sim/joystick_axis_command_mapper_test.sv @@
// Self-checking testbench for the joystick axis command mapper: random polls, flow control, CSRs.
// Depends on jacm_pkg, the jacm channel interfaces and the joystick_axis_command_mapper RTL.
`timescale 1ns / 1ps

module joystick_axis_command_mapper_test import jacm_pkg::*; ();

   localparam int    CLK_HALF       = 5;
   localparam int    RESET_CYCLES   = 6;
   localparam int    SETTLE_CYCLES  = 60;
   localparam int    TIMEOUT_CYCLES = 300000;
   localparam int    PHASE_POLLS    = 90;
   localparam int    LONG_HOLD      = 400;
   localparam longint SPAN          = longint'(AXIS_SPAN);
   localparam longint LIMIT         = longint'(FULL_SCALE);
   // No register lives at this index, so writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 4'd15;

   typedef struct {
      axis_type axis_pov_y;
      axis_type axis_pov_x;
      axis_type axis_r;
      axis_type axis_y;
      axis_type axis_x;
      axis_type axis_z;
      axis_type axis_u;
      axis_type axis_v;
      btn_type  buttons;
   } joystick_poll_type;

   typedef struct {
      cmd_type                    pitch_cmd;
      cmd_type                    roll_cmd;
      cmd_type                    yaw_cmd;
      cmd_type                    surge_cmd;
      cmd_type                    sway_cmd;
      cmd_type                    depth_cmd;
      logic signed [GRIP_W-1:0]   grip_cmd;
      logic signed [TILT_W-1:0]   tilt_cmd;
      logic signed [AUX_W-1:0]    aux_thruster_cmd;
      logic signed [LAMP_W-1:0]   lamp_cmd;
      axis_type                   grip_rotate;
      logic [NUM_STAB-1:0]        stabilize_flags;
   } command_packet_type;

   // Predicts command packets from accepted polls and checks delivered packets in order
   class command_scoreboard;
      bit                invert_depth;
      hold_type          holdoff;
      logic [NUM_STAB-1:0] hold_flags;
      hold_type          press_wait [NUM_STAB];
      command_packet_type packet_q [$];
      int                failures;

      function new();
         invert_depth = 1'b0;
         holdoff      = HOLDOFF_RESET;
         hold_flags   = '0;
         foreach (press_wait[i]) press_wait[i] = '0;
         failures     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_INVERT_DEPTH:   invert_depth = data[0];
            REG_BUTTON_HOLDOFF: holdoff = data;
            default: ;
         endcase
      endfunction

      function longint clamp(longint v);
         if (v > LIMIT) return LIMIT;
         if (v < -LIMIT) return -LIMIT;
         return v;
      endfunction

      function longint scale_axis(axis_type a);
         return clamp(longint'(a) * LIMIT / SPAN);
      endfunction

      function void note_poll(joystick_poll_type p);
         longint          motion [NUM_CMD];
         longint          gain;
         logic [NUM_STAB-1:0] press;
         command_packet_type e;
         gain      = longint'(p.axis_u) + SPAN;
         motion[0] = scale_axis(p.axis_pov_y);
         motion[1] = scale_axis(p.axis_pov_x);
         motion[2] = scale_axis(p.axis_r);
         motion[3] = -scale_axis(p.axis_y);
         motion[4] = scale_axis(p.axis_x);
         motion[5] = clamp((SPAN - longint'(p.axis_z)) * LIMIT / (2 * SPAN));
         if (invert_depth) motion[5] = -motion[5];
         // apply the sensitivity factor (u + span) / (2 * span)
         foreach (motion[i]) motion[i] = clamp(motion[i] * gain / (2 * SPAN));

         // toggle a held stabilize button, then count down its holdoff
         press = p.buttons[BTN_STAB_DEPTH +: NUM_STAB];
         for (int i = 0; i < NUM_STAB; i++) begin
            if (press[i] && press_wait[i] == 0) begin
               hold_flags[i] = ~hold_flags[i];
               press_wait[i] = holdoff;
            end
            if (press_wait[i] != 0) press_wait[i]--;
         end
         if (p.buttons[BTN_DEPTH_FLIP]) motion[5] = -motion[5];

         e.pitch_cmd = cmd_type'(motion[0]);
         e.roll_cmd  = cmd_type'(motion[1]);
         e.yaw_cmd   = cmd_type'(motion[2]);
         e.surge_cmd = cmd_type'(motion[3]);
         e.sway_cmd  = cmd_type'(motion[4]);
         e.depth_cmd = cmd_type'(motion[5]);
         // open beats close, tilt up beats tilt down, forward beats reverse
         if (p.buttons[BTN_JAW_OPEN]) e.grip_cmd = GRIP_OPEN;
         else if (p.buttons[BTN_JAW_CLOSE] || p.buttons[BTN_JAW_CLOSE_HARD])
            e.grip_cmd = GRIP_CLOSE;
         else e.grip_cmd = '0;
         if (p.buttons[BTN_CAM_RAISE]) e.tilt_cmd = TILT_RAISE;
         else if (p.buttons[BTN_TILT_DN]) e.tilt_cmd = TILT_LOWER;
         else e.tilt_cmd = '0;
         if (p.buttons[BTN_FWD]) e.aux_thruster_cmd = AUX_FWD;
         else if (p.buttons[BTN_REV]) e.aux_thruster_cmd = AUX_REV;
         else e.aux_thruster_cmd = '0;
         e.lamp_cmd        = p.buttons[BTN_LIGHT] ? LAMP_ON : '0;
         e.grip_rotate     = p.axis_v;
         e.stabilize_flags = hold_flags;
         packet_q.push_back(e);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_packet(command_packet_type got);
         command_packet_type want;
         if (packet_q.size() == 0) begin
            $error("command packet delivered with no poll outstanding");
            failures++;
            return;
         end
         want = packet_q.pop_front();
         compare_field("pitch_cmd", want.pitch_cmd, got.pitch_cmd);
         compare_field("roll_cmd", want.roll_cmd, got.roll_cmd);
         compare_field("yaw_cmd", want.yaw_cmd, got.yaw_cmd);
         compare_field("surge_cmd", want.surge_cmd, got.surge_cmd);
         compare_field("sway_cmd", want.sway_cmd, got.sway_cmd);
         compare_field("depth_cmd", want.depth_cmd, got.depth_cmd);
         compare_field("grip_cmd", want.grip_cmd, got.grip_cmd);
         compare_field("tilt_cmd", want.tilt_cmd, got.tilt_cmd);
         compare_field("aux_thruster_cmd", want.aux_thruster_cmd, got.aux_thruster_cmd);
         compare_field("lamp_cmd", want.lamp_cmd, got.lamp_cmd);
         compare_field("grip_rotate", want.grip_rotate, got.grip_rotate);
         compare_field("stabilize_flags", want.stabilize_flags, got.stabilize_flags);
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   jacm_req_if req_if ();
   jacm_rsp_if rsp_if ();
   jacm_csr_if csr_if ();

   joystick_axis_command_mapper i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   command_scoreboard packets = new();
   command_packet_type rsp_seen;
   logic [NUM_STAB-1:0] held_stab = '0;
   int                rsp_hold_cycles = 0;

   // Free-running clock
   always begin
      clock = 1'b1;
      #(CLK_HALF);
      clock = 1'b0;
      #(CLK_HALF);
   end

   // Hard stop if the run hangs
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("*** FAILED ***");
      $finish;
   end

   // Axis value: mostly in range, with extremes, near-zero and raw 15-bit values
   function automatic axis_type random_axis();
      case ($urandom_range(0, 9))
         0: return axis_type'(AXIS_SPAN);
         1: return -axis_type'(AXIS_SPAN);
         2: return axis_type'($urandom);
         3: return axis_type'(int'($urandom_range(0, 200)) - 100);
         default: return axis_type'(int'($urandom_range(0, 20000)) - 10000);
      endcase
   endfunction

   // Random poll; stabilize buttons are held over runs of polls so the holdoff matters
   function automatic joystick_poll_type random_poll();
      joystick_poll_type p;
      p.axis_pov_y = random_axis();
      p.axis_pov_x = random_axis();
      p.axis_r     = random_axis();
      p.axis_y     = random_axis();
      p.axis_x     = random_axis();
      p.axis_z     = random_axis();
      p.axis_u     = random_axis();
      p.axis_v     = random_axis();
      if ($urandom_range(0, 7) == 0) held_stab = NUM_STAB'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) p.buttons = btn_type'($urandom);
      else p.buttons = {held_stab, 9'($urandom)};
      return p;
   endfunction

   function automatic joystick_poll_type make_poll(axis_type a, axis_type u, btn_type b);
      joystick_poll_type p;
      p.axis_pov_y = a;
      p.axis_pov_x = a;
      p.axis_r     = a;
      p.axis_y     = a;
      p.axis_x     = a;
      p.axis_z     = a;
      p.axis_u     = u;
      p.axis_v     = a;
      p.buttons    = b;
      return p;
   endfunction

   // Offer one poll and hold it until the block takes it
   task automatic send_poll(joystick_poll_type p);
      @(negedge clock);
      req_if.valid      = 1'b1;
      req_if.axis_pov_y = p.axis_pov_y;
      req_if.axis_pov_x = p.axis_pov_x;
      req_if.axis_r     = p.axis_r;
      req_if.axis_y     = p.axis_y;
      req_if.axis_x     = p.axis_x;
      req_if.axis_z     = p.axis_z;
      req_if.axis_u     = p.axis_u;
      req_if.axis_v     = p.axis_v;
      req_if.buttons    = p.buttons;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      packets.note_poll(p);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = index;
      csr_if.data  = data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      packets.set_register(index, data);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Stop sending and wait for every outstanding packet
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (packets.packet_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: runs of ready with short stalls, plus long hold-offs on request
   initial begin : rsp_ready_drive
      int run_left;
      int stall_left;
      run_left     = 0;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left != 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready = 1'b1;
            if (run_left != 0) begin
               run_left--;
            end else begin
               run_left   = $urandom_range(1, 12);
               stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Check each delivered packet
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         rsp_seen.pitch_cmd        = rsp_if.pitch_cmd;
         rsp_seen.roll_cmd         = rsp_if.roll_cmd;
         rsp_seen.yaw_cmd          = rsp_if.yaw_cmd;
         rsp_seen.surge_cmd        = rsp_if.surge_cmd;
         rsp_seen.sway_cmd         = rsp_if.sway_cmd;
         rsp_seen.depth_cmd        = rsp_if.depth_cmd;
         rsp_seen.grip_cmd         = rsp_if.grip_cmd;
         rsp_seen.tilt_cmd         = rsp_if.tilt_cmd;
         rsp_seen.aux_thruster_cmd = rsp_if.aux_thruster_cmd;
         rsp_seen.lamp_cmd         = rsp_if.lamp_cmd;
         rsp_seen.grip_rotate      = rsp_if.grip_rotate;
         rsp_seen.stabilize_flags  = rsp_if.stabilize_flags;
         packets.check_packet(rsp_seen);
      end
   end

   // Main sequence: reset, directed polls, then random phases under several settings
   initial begin : stimulus
      bit       phase_invert [5];
      hold_type phase_holdoff [5];
      int       burst_left;
      int       gap;
      req_if.valid      = 1'b0;
      req_if.axis_pov_y = '0;
      req_if.axis_pov_x = '0;
      req_if.axis_r     = '0;
      req_if.axis_y     = '0;
      req_if.axis_x     = '0;
      req_if.axis_z     = '0;
      req_if.axis_u     = '0;
      req_if.axis_v     = '0;
      req_if.buttons    = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      phase_invert  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      phase_holdoff = '{8'd1, 8'd255, 8'd0, 8'd5, hold_type'($urandom_range(2, 20))};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, saturation, zero and negative sensitivity
      send_poll(make_poll(0, 0, '0));
      send_poll(make_poll(10000, 10000, '0));
      send_poll(make_poll(-10000, 10000, '0));
      send_poll(make_poll(16383, 16383, '0));
      send_poll(make_poll(-16384, -16384, '0));
      send_poll(make_poll(5000, -10000, '0));
      send_poll(make_poll(-16384, 16383, '0));
      // every button alone
      for (int k = 0; k < BTN_W; k++)
         send_poll(make_poll(axis_type'(k * 1000 - 5000), axis_type'(k * 500), btn_type'(1) << k));
      // conflicting buttons and everything pressed
      send_poll(make_poll(7777, 2500, btn_type'((1 << BTN_JAW_OPEN) | (1 << BTN_JAW_CLOSE)
                                                | (1 << BTN_JAW_CLOSE_HARD))));
      send_poll(make_poll(-7777, 2500, btn_type'((1 << BTN_CAM_RAISE) | (1 << BTN_TILT_DN))));
      send_poll(make_poll(3333, -2500, btn_type'((1 << BTN_FWD) | (1 << BTN_REV))));
      send_poll(make_poll(-3333, 9999, '1));

      // Random phases, each under its own register settings
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         write_register(REG_INVERT_DEPTH, CSR_DATA_W'(phase_invert[ph]));
         write_register(REG_BUTTON_HOLDOFF, phase_holdoff[ph]);
         if (ph == 3) write_register(REG_SPARE, CSR_DATA_W'($urandom));
         burst_left = 0;
         for (int n = 0; n < PHASE_POLLS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap != 0) begin
                  @(negedge clock);
                  req_if.valid = 1'b0;
                  repeat (gap - 1) @(negedge clock);
               end
            end
            // choke the output while polls keep coming
            if (n == 20 && (ph == 1 || ph == 3)) rsp_hold_cycles = LONG_HOLD;
            send_poll(random_poll());
            burst_left--;
         end
      end

      wait_drained();
      if (packets.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
